// ===== sv/ctg_pkg.sv =====
package ctg_pkg;

  localparam int TEMP_BITS     = 12;
  localparam int RUN_BITS      = 4;
  localparam int CFG_ADDR_BITS = 3;

  typedef logic signed [TEMP_BITS-1:0] temp_t;
  typedef logic [RUN_BITS-1:0]         run_t;

  localparam temp_t LOW_WIN_LO  = temp_t'(-160);
  localparam temp_t LOW_WIN_HI  = temp_t'(-16);
  localparam temp_t HIGH_WIN_LO = temp_t'(16);

  localparam temp_t RST_COMPRESSOR_LIMIT      = temp_t'(1280);
  localparam temp_t RST_DISCHARGE_LIMIT       = temp_t'(1360);
  localparam temp_t RST_INTAKE_LOW_LIMIT      = temp_t'(-120);
  localparam run_t  RST_PERSIST_COUNT         = run_t'(3);
  localparam temp_t RST_COMPRESSOR_VALID_HIGH = temp_t'(1280);
  localparam temp_t RST_DISCHARGE_VALID_HIGH  = temp_t'(1440);
  localparam temp_t RST_INTAKE_VALID_HIGH     = temp_t'(960);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_COMPRESSOR_LIMIT      = 3'd0,
    REG_DISCHARGE_LIMIT       = 3'd1,
    REG_INTAKE_LOW_LIMIT      = 3'd2,
    REG_PERSIST_COUNT         = 3'd3,
    REG_COMPRESSOR_VALID_HIGH = 3'd4,
    REG_DISCHARGE_VALID_HIGH  = 3'd5,
    REG_INTAKE_VALID_HIGH     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    temp_t compressor_raw;
    temp_t discharge_raw;
    temp_t intake_raw;
    logic  clear_alarms;
  } in_item_t;

  typedef struct packed {
    temp_t compressor_average;
    temp_t discharge_average;
    logic  compressor_alarm;
    logic  discharge_alarm;
    logic  intake_alarm;
    logic  compressor_accepted;
    logic  discharge_accepted;
    logic  intake_accepted;
  } out_item_t;

  typedef struct packed {
    temp_t held;
    logic  accepted;
  } sensor_t;

  typedef struct packed {
    temp_t average;
    logic  alarm_set;
  } avg_t;

endpackage

// ===== sv/ctg_sensor.sv =====
module ctg_sensor
  import ctg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    upd,
  input  temp_t   raw,
  input  temp_t   valid_high,
  output sensor_t status
);

  temp_t held_r;
  logic  accepted;

  assign accepted = (raw > LOW_WIN_LO && raw < LOW_WIN_HI) ||
                    (raw > HIGH_WIN_LO && raw < valid_high);

  assign status.accepted = accepted;
  assign status.held     = accepted ? raw : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (upd) begin
      held_r <= status.held;
    end
  end

endmodule

// ===== sv/ctg_average.sv =====
module ctg_average
  import ctg_pkg::*;
#(
  parameter int TAPS = 5
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  upd,
  input  temp_t sample,
  input  temp_t limit,
  input  run_t  persist,
  output avg_t  result
);

  localparam int SUM_W   = TEMP_BITS + $clog2(TAPS) + 1;
  localparam int MAG_W   = SUM_W - 1;
  localparam int SHIFT   = MAG_W + $clog2(TAPS);
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam longint unsigned RECIP = ((longint'(1) << SHIFT) + TAPS - 1) / TAPS;

  typedef logic signed [SUM_W-1:0] sum_t;

  temp_t               win_r [TAPS];
  sum_t                sum_r;
  sum_t                sum_nxt;
  sum_t                limit_sum;
  sum_t                abs_full;
  run_t                run_r;
  run_t                run_nxt;
  logic [RUN_BITS:0]   run_inc;
  logic                exceed;
  logic                neg;
  logic [MAG_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;
  logic [MAG_W:0]      quo;
  logic [MAG_W:0]      quo_s;

  // running window sum: drop the oldest tap, add the new sample
  assign sum_nxt   = sum_r - sum_t'(win_r[TAPS-1]) + sum_t'(sample);
  assign limit_sum = sum_t'(limit) * sum_t'(TAPS);
  assign exceed    = sum_nxt > limit_sum;

  assign run_inc = {1'b0, run_r} + (RUN_BITS+1)'(1);
  assign run_nxt = !exceed ? '0 : (run_inc[RUN_BITS] ? '1 : run_inc[RUN_BITS-1:0]);

  assign result.alarm_set = exceed && (run_inc > {1'b0, persist});

  // divide by TAPS through a reciprocal, truncating toward zero
  assign neg      = sum_nxt[SUM_W-1];
  assign abs_full = neg ? sum_t'(-sum_nxt) : sum_nxt;
  assign mag      = abs_full[MAG_W-1:0];
  assign prod     = PROD_W'(mag) * PROD_W'(RECIP_W'(RECIP));
  assign quo      = prod[PROD_W-1:SHIFT];
  assign quo_s    = neg ? (MAG_W+1)'(-quo) : quo;

  assign result.average = quo_s[TEMP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        win_r[i] <= '0;
      end
      sum_r <= '0;
      run_r <= '0;
    end else if (upd) begin
      win_r[0] <= sample;
      for (int i = 1; i < TAPS; i++) begin
        win_r[i] <= win_r[i-1];
      end
      sum_r <= sum_nxt;
      run_r <= run_nxt;
    end
  end

endmodule

// ===== sv/compressor_temperature_guard.sv =====
// Takes one measurement round per clock while out_stall is low: an accepted item sits in an input
// register and its result is loaded into the output register when the item advances, so out_valid
// rises with that load and a new item is accepted in the same cycle as the previous one advances.
// The whole round (plausibility check, held value, running window sums, limit compares,
// persistence counters, sticky alarms and the constant divide for the averages) is one
// registered pass. While out_stall holds a full output register and the input register is
// occupied, in_stall rises. Configuration writes take effect on the next edge and should be
// made while the block is idle; the averages read the window with the new sample included.
module compressor_temperature_guard
  import ctg_pkg::*;
#(
  parameter int COMPRESSOR_TAPS = 5,
  parameter int DISCHARGE_TAPS  = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_item,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [TEMP_BITS-1:0]     cfg_wdata
);

  temp_t     compressor_limit_r;
  temp_t     discharge_limit_r;
  temp_t     intake_low_limit_r;
  run_t      persist_count_r;
  temp_t     compressor_valid_high_r;
  temp_t     discharge_valid_high_r;
  temp_t     intake_valid_high_r;

  logic      a_valid_r;
  in_item_t  a_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic [2:0] alarm_r;
  logic [2:0] alarm_nxt;
  logic       accept;
  logic       advance;
  logic       intake_low;

  sensor_t   comp_s;
  sensor_t   disch_s;
  sensor_t   intake_s;
  avg_t      comp_a;
  avg_t      disch_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compressor_limit_r      <= RST_COMPRESSOR_LIMIT;
      discharge_limit_r       <= RST_DISCHARGE_LIMIT;
      intake_low_limit_r      <= RST_INTAKE_LOW_LIMIT;
      persist_count_r         <= RST_PERSIST_COUNT;
      compressor_valid_high_r <= RST_COMPRESSOR_VALID_HIGH;
      discharge_valid_high_r  <= RST_DISCHARGE_VALID_HIGH;
      intake_valid_high_r     <= RST_INTAKE_VALID_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_COMPRESSOR_LIMIT:      compressor_limit_r      <= cfg_wdata;
        REG_DISCHARGE_LIMIT:       discharge_limit_r       <= cfg_wdata;
        REG_INTAKE_LOW_LIMIT:      intake_low_limit_r      <= cfg_wdata;
        REG_PERSIST_COUNT:         persist_count_r         <= cfg_wdata[RUN_BITS-1:0];
        REG_COMPRESSOR_VALID_HIGH: compressor_valid_high_r <= cfg_wdata;
        REG_DISCHARGE_VALID_HIGH:  discharge_valid_high_r  <= cfg_wdata;
        REG_INTAKE_VALID_HIGH:     intake_valid_high_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance  = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r <= in_item;
    end
  end

  ctg_sensor u_comp_sensor (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (advance),
    .raw        (a_item_r.compressor_raw),
    .valid_high (compressor_valid_high_r),
    .status     (comp_s)
  );

  ctg_sensor u_disch_sensor (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (advance),
    .raw        (a_item_r.discharge_raw),
    .valid_high (discharge_valid_high_r),
    .status     (disch_s)
  );

  ctg_sensor u_intake_sensor (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (advance),
    .raw        (a_item_r.intake_raw),
    .valid_high (intake_valid_high_r),
    .status     (intake_s)
  );

  ctg_average #(.TAPS(COMPRESSOR_TAPS)) u_comp_avg (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (advance),
    .sample  (comp_s.held),
    .limit   (compressor_limit_r),
    .persist (persist_count_r),
    .result  (comp_a)
  );

  ctg_average #(.TAPS(DISCHARGE_TAPS)) u_disch_avg (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (advance),
    .sample  (disch_s.held),
    .limit   (discharge_limit_r),
    .persist (persist_count_r),
    .result  (disch_a)
  );

  assign intake_low = intake_s.held < intake_low_limit_r;

  // clear first, then set from this round
  assign alarm_nxt = (a_item_r.clear_alarms ? 3'b000 : alarm_r) |
                     {intake_low, disch_a.alarm_set, comp_a.alarm_set};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r <= '0;
    end else if (advance) begin
      alarm_r <= alarm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.compressor_average  <= comp_a.average;
      out_item_r.discharge_average   <= disch_a.average;
      out_item_r.compressor_alarm    <= alarm_nxt[0];
      out_item_r.discharge_alarm     <= alarm_nxt[1];
      out_item_r.intake_alarm        <= alarm_nxt[2];
      out_item_r.compressor_accepted <= comp_s.accepted;
      out_item_r.discharge_accepted  <= disch_s.accepted;
      out_item_r.intake_accepted     <= intake_s.accepted;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/ctg_checker.sv =====
module ctg_checker
  import ctg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

endmodule

bind compressor_temperature_guard ctg_checker u_ctg_checker (.*);

// ===== dv/tb_compressor_temperature_guard.sv =====
`timescale 1ns / 1ps

module tb_compressor_temperature_guard;
  import ctg_pkg::*;

  localparam int COMP_TAPS   = 5;
  localparam int DISC_TAPS   = 3;
  localparam int NEG_WIN_LO  = -160;
  localparam int NEG_WIN_HI  = -16;
  localparam int POS_WIN_LO  = 16;
  localparam int RUN_TOP     = 15;
  localparam int STALL_LIMIT = 200;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 80;
  localparam int TEMP_MIN    = -2048;
  localparam int TEMP_MAX    = 2047;

  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 3'd7;
  localparam out_item_t QUIET_ROUND = '0;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } plan_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_item;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_item;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [TEMP_BITS-1:0]     cfg_wdata;

  logic      row_typed;
  out_item_t row_want;
  logic      steady;

  compressor_temperature_guard dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  temp_t comp_limit, disc_limit, intake_low;
  run_t  persist_rounds;
  temp_t comp_vhigh, disc_vhigh, intake_vhigh;

  temp_t held_comp, held_disc, held_intake;
  temp_t comp_taps [COMP_TAPS];
  temp_t disc_taps [DISC_TAPS];
  run_t  comp_run, disc_run;
  logic  comp_alarm, disc_alarm, intake_alarm;

  out_item_t expected_rounds [$];
  plan_row_t plan [$];

  int mismatches   = 0;
  int rounds_sent  = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int alarm_rounds = 0;
  int rejects      = 0;
  int quiet_cycles = 0;

  int lvl [3];
  int left [3];

  task automatic reset_guard_model();
    comp_limit     = temp_t'(1280);
    disc_limit     = temp_t'(1360);
    intake_low     = temp_t'(-120);
    persist_rounds = run_t'(3);
    comp_vhigh     = temp_t'(1280);
    disc_vhigh     = temp_t'(1440);
    intake_vhigh   = temp_t'(960);
    held_comp      = '0;
    held_disc      = '0;
    held_intake    = '0;
    foreach (comp_taps[i]) comp_taps[i] = '0;
    foreach (disc_taps[i]) disc_taps[i] = '0;
    comp_run       = '0;
    disc_run       = '0;
    comp_alarm     = 1'b0;
    disc_alarm     = 1'b0;
    intake_alarm   = 1'b0;
  endtask

  task automatic apply_register(logic [CFG_ADDR_BITS-1:0] idx, logic [TEMP_BITS-1:0] val);
    case (idx)
      REG_COMPRESSOR_LIMIT:      comp_limit = temp_t'(val);
      REG_DISCHARGE_LIMIT:       disc_limit = temp_t'(val);
      REG_INTAKE_LOW_LIMIT:      intake_low = temp_t'(val);
      REG_PERSIST_COUNT:         persist_rounds = val[RUN_BITS-1:0];
      REG_COMPRESSOR_VALID_HIGH: comp_vhigh = temp_t'(val);
      REG_DISCHARGE_VALID_HIGH:  disc_vhigh = temp_t'(val);
      REG_INTAKE_VALID_HIGH:     intake_vhigh = temp_t'(val);
      default: ;
    endcase
  endtask

  function automatic logic in_window(int x, int hi);
    return (x > NEG_WIN_LO && x < NEG_WIN_HI) || (x > POS_WIN_LO && x < hi);
  endfunction

  // returns {alarm_set, next_run}
  function automatic logic [RUN_BITS:0] advance_run(run_t run, logic over);
    int nxt;
    if (!over) return '0;
    nxt = int'(run) + 1;
    return {nxt > int'(persist_rounds), run_t'(nxt > RUN_TOP ? RUN_TOP : nxt)};
  endfunction

  function automatic out_item_t guard_round(in_item_t r);
    int        c, d, t, csum, dsum;
    logic      ca, da, ta, hit;
    out_item_t o;
    c  = int'(r.compressor_raw);
    d  = int'(r.discharge_raw);
    t  = int'(r.intake_raw);
    ca = in_window(c, int'(comp_vhigh));
    da = in_window(d, int'(disc_vhigh));
    ta = in_window(t, int'(intake_vhigh));
    if (r.clear_alarms) begin
      comp_alarm   = 1'b0;
      disc_alarm   = 1'b0;
      intake_alarm = 1'b0;
    end
    if (ca) held_comp = r.compressor_raw;
    if (da) held_disc = r.discharge_raw;
    if (ta) held_intake = r.intake_raw;
    for (int i = COMP_TAPS - 1; i > 0; i--) comp_taps[i] = comp_taps[i-1];
    comp_taps[0] = held_comp;
    for (int i = DISC_TAPS - 1; i > 0; i--) disc_taps[i] = disc_taps[i-1];
    disc_taps[0] = held_disc;
    csum = 0;
    dsum = 0;
    foreach (comp_taps[i]) csum += int'(comp_taps[i]);
    foreach (disc_taps[i]) dsum += int'(disc_taps[i]);
    {hit, comp_run} = advance_run(comp_run, csum > int'(comp_limit) * COMP_TAPS);
    if (hit) comp_alarm = 1'b1;
    {hit, disc_run} = advance_run(disc_run, dsum > int'(disc_limit) * DISC_TAPS);
    if (hit) disc_alarm = 1'b1;
    if (int'(held_intake) < int'(intake_low)) intake_alarm = 1'b1;
    o.compressor_average  = temp_t'(csum / COMP_TAPS);
    o.discharge_average   = temp_t'(dsum / DISC_TAPS);
    o.compressor_alarm    = comp_alarm;
    o.discharge_alarm     = disc_alarm;
    o.intake_alarm        = intake_alarm;
    o.compressor_accepted = ca;
    o.discharge_accepted  = da;
    o.intake_accepted     = ta;
    return o;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on result %0d: %s got %0d, expected %0d", results_seen, field, got,
             want);
    mismatches++;
  endtask

  task automatic check_result(out_item_t got, out_item_t want);
    if (got.compressor_average !== want.compressor_average)
      report_mismatch("compressor_average", got.compressor_average, want.compressor_average);
    if (got.discharge_average !== want.discharge_average)
      report_mismatch("discharge_average", got.discharge_average, want.discharge_average);
    if (got.compressor_alarm !== want.compressor_alarm)
      report_mismatch("compressor_alarm", got.compressor_alarm, want.compressor_alarm);
    if (got.discharge_alarm !== want.discharge_alarm)
      report_mismatch("discharge_alarm", got.discharge_alarm, want.discharge_alarm);
    if (got.intake_alarm !== want.intake_alarm)
      report_mismatch("intake_alarm", got.intake_alarm, want.intake_alarm);
    if (got.compressor_accepted !== want.compressor_accepted)
      report_mismatch("compressor_accepted", got.compressor_accepted,
                      want.compressor_accepted);
    if (got.discharge_accepted !== want.discharge_accepted)
      report_mismatch("discharge_accepted", got.discharge_accepted, want.discharge_accepted);
    if (got.intake_accepted !== want.intake_accepted)
      report_mismatch("intake_accepted", got.intake_accepted, want.intake_accepted);
  endtask

  always @(posedge clk) begin : scoreboard
    out_item_t pred;
    if (rst_n && in_valid && !in_stall) begin
      pred = guard_round(in_item);
      rejects += 3 - (pred.compressor_accepted + pred.discharge_accepted
                      + pred.intake_accepted);
      expected_rounds.push_back(row_typed ? row_want : pred);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rounds.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        check_result(out_item, expected_rounds.pop_front());
      end
      if (out_item.compressor_alarm || out_item.discharge_alarm || out_item.intake_alarm)
        alarm_rounds++;
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int idle_draw();
    return steady ? 0 : int'($urandom_range(0, 4));
  endfunction

  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = idle_draw();
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_round(in_item_t it, logic typed, out_item_t want);
    int gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_item   <= it;
    row_typed <= typed;
    row_want  <= want;
    rounds_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_rounds();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rounds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_BITS-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= TEMP_BITS'(val);
    apply_register(idx, TEMP_BITS'(val));
    cfg_writes++;
  endtask

  task automatic program_guard(int cl, int dl, int il, int pc, int cv, int dv, int iv);
    cfg_write(REG_COMPRESSOR_LIMIT, cl);
    cfg_write(REG_DISCHARGE_LIMIT, dl);
    cfg_write(REG_INTAKE_LOW_LIMIT, il);
    cfg_write(REG_PERSIST_COUNT, pc);
    cfg_write(REG_COMPRESSOR_VALID_HIGH, cv);
    cfg_write(REG_DISCHARGE_VALID_HIGH, dv);
    cfg_write(REG_INTAKE_VALID_HIGH, iv);
    cfg_write(REG_SPARE, int'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t make_round(int c, int d, int t, logic clr);
    in_item_t it;
    it.compressor_raw = temp_t'(c);
    it.discharge_raw  = temp_t'(d);
    it.intake_raw     = temp_t'(t);
    it.clear_alarms   = clr;
    return it;
  endfunction

  function automatic out_item_t make_result(int ca, int da, logic [2:0] alarms,
                                            logic [2:0] accepted);
    return {temp_t'(ca), temp_t'(da), alarms, accepted};
  endfunction

  function automatic void add_row(int c, int d, int t, logic clr, logic typed,
                                  out_item_t want);
    plan_row_t row;
    row.stim  = make_round(c, d, t, clr);
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic int draw_level(int hi);
    if (hi > POS_WIN_LO + 2 && $urandom_range(0, 3) != 0)
      return int'($urandom_range(POS_WIN_LO + 1, hi - 1));
    return -int'($urandom_range(-NEG_WIN_HI + 1, -NEG_WIN_LO - 1));
  endfunction

  // mostly hold near a level, now and then a jump or a wild reading
  function automatic int draw_reading(int level);
    int pick;
    pick = int'($urandom_range(0, 15));
    if (pick == 0) return int'(temp_t'($urandom));
    if (pick == 1) return level + 16 * int'($urandom_range(0, 8)) - 64;
    return level + int'($urandom_range(0, 6)) - 3;
  endfunction

  function automatic in_item_t draw_round();
    int hi [3];
    int val [3];
    hi[0] = int'(comp_vhigh);
    hi[1] = int'(disc_vhigh);
    hi[2] = int'(intake_vhigh);
    for (int s = 0; s < 3; s++) begin
      if (left[s] == 0) begin
        lvl[s]  = draw_level(hi[s]);
        left[s] = int'($urandom_range(1, 24));
      end
      left[s]--;
      val[s] = draw_reading(lvl[s]);
    end
    return make_round(val[0], val[1], val[2], $urandom_range(0, 11) == 0);
  endfunction

  task automatic set_phase(int p);
    int vh;
    case (p)
      0: program_guard(TEMP_MIN, TEMP_MIN, TEMP_MAX, int'($urandom) & 'hFF0,
                       TEMP_MAX, TEMP_MAX, TEMP_MAX);
      1: program_guard(TEMP_MAX, TEMP_MAX, TEMP_MIN, (int'($urandom) & 'hFF0) | RUN_TOP,
                       TEMP_MIN, TEMP_MIN, TEMP_MIN);
      2: program_guard(int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200,
                       int'($urandom_range(0, 160)) - 170, int'($urandom),
                       POS_WIN_LO, POS_WIN_LO + 1, TEMP_MIN);
      3: program_guard(TEMP_MIN, TEMP_MIN, NEG_WIN_LO, RUN_TOP, TEMP_MAX, TEMP_MAX, TEMP_MAX);
      default: begin
        vh = int'($urandom_range(100, TEMP_MAX));
        program_guard(int'($urandom_range(0, vh + 100)) - 100,
                      int'($urandom_range(0, vh + 100)) - 100,
                      int'($urandom_range(0, 200)) - 180, int'($urandom),
                      vh, int'($urandom_range(100, TEMP_MAX)),
                      int'($urandom_range(100, TEMP_MAX)));
      end
    endcase
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    row_typed = 1'b0;
    row_want  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    steady    = 1'b0;
    foreach (left[s]) left[s] = 0;
    reset_guard_model();

    add_row(0, 0, 0, 1'b0, 1'b1, QUIET_ROUND);
    add_row(TEMP_MIN, TEMP_MAX, TEMP_MIN, 1'b1, 1'b1, QUIET_ROUND);
    add_row(TEMP_MAX, TEMP_MIN, TEMP_MAX, 1'b0, 1'b1, QUIET_ROUND);
    add_row(NEG_WIN_LO, NEG_WIN_LO, NEG_WIN_LO, 1'b0, 1'b1, QUIET_ROUND);
    add_row(NEG_WIN_HI, NEG_WIN_HI, NEG_WIN_HI, 1'b1, 1'b1, QUIET_ROUND);
    add_row(POS_WIN_LO, POS_WIN_LO, POS_WIN_LO, 1'b0, 1'b1, QUIET_ROUND);
    add_row(1280, 1440, 960, 1'b0, 1'b1, QUIET_ROUND);
    add_row(-159, -17, 17, 1'b0, 1'b1, make_result(-31, -5, 3'b000, 3'b111));
    add_row(-17, -159, -159, 1'b0, 1'b0, QUIET_ROUND);
    repeat (7) add_row(1279, 1439, 959, 1'b0, 1'b0, QUIET_ROUND);
    add_row(-100, 500, 100, 1'b1, 1'b0, QUIET_ROUND);
    add_row(0, 0, 0, 1'b0, 1'b0, QUIET_ROUND);
    add_row(TEMP_MIN, TEMP_MIN, TEMP_MAX, 1'b1, 1'b0, QUIET_ROUND);
    add_row(TEMP_MAX, TEMP_MAX, TEMP_MIN, 1'b0, 1'b0, QUIET_ROUND);
    add_row(-121, 1300, -121, 1'b0, 1'b0, QUIET_ROUND);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_round(plan[i].stim, plan[i].typed, plan[i].want);
    drain_rounds();

    for (int p = 0; p < PHASES; p++) begin
      set_phase(p);
      steady = (p % 3 == 2);
      foreach (left[s]) left[s] = 0;
      repeat (PHASE_ITEMS) send_round(draw_round(), 1'b0, QUIET_ROUND);
      drain_rounds();
    end

    $display("covered %0d rounds over %0d settings and %0d register writes", rounds_sent,
             PHASES + 1, cfg_writes);
    $display("checked %0d results, %0d carried an alarm, %0d readings rejected",
             results_seen, alarm_rounds, rejects);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
